// ===== rtl/erpd_pkg.sv =====
package erpd_pkg;

  localparam logic [7:0] MARK_BYTE    = 8'hED;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;
  localparam int         HEADER_BYTES = 3;

  localparam int MAX_RESULTS    = 3;
  localparam int QUEUE_DEPTH    = 4;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic REG_FORMAT_MODE = 1'b0;

  localparam logic MODE_TERMINATED = 1'b0;
  localparam logic MODE_CHUNKED    = 1'b1;

  typedef enum logic [13:0] {
    PH_T_IDLE = 14'b00000000000001,
    PH_T_E    = 14'b00000000000010,
    PH_T_EE   = 14'b00000000000100,
    PH_T_EEN  = 14'b00000000001000,
    PH_T_Z    = 14'b00000000010000,
    PH_T_ZE   = 14'b00000000100000,
    PH_T_ZEE  = 14'b00000001000000,
    PH_C_H0   = 14'b00000010000000,
    PH_C_H1   = 14'b00000100000000,
    PH_C_H2   = 14'b00001000000000,
    PH_C_D    = 14'b00010000000000,
    PH_C_E    = 14'b00100000000000,
    PH_C_EE   = 14'b01000000000000,
    PH_C_EEN  = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    logic [7:0]                   page;
    logic [1:0]                   n;
    logic [MAX_RESULTS-1:0][7:0]  val;
    logic [MAX_RESULTS-1:0][7:0]  len;
    logic                         last_end;
  } run_entry_t;

endpackage

// ===== rtl/erpd_if.sv =====
interface erpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface erpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] page_number;
  logic [7:0] run_value;
  logic [7:0] run_length;
  logic       block_end;

  modport source (output valid, output page_number, output run_value, output run_length,
                  output block_end, input ready);
  modport sink (input valid, input page_number, input run_value, input run_length,
                input block_end, output ready);
endinterface

// ===== rtl/ed_rle_page_decoder.sv =====
// ED ED run-length page decoder.
// byte_in takes one compressed byte per item (valid/ready); run_out delivers
// decoded runs as page_number, run_value, run_length and block_end items.
// A run_length of zero writes nothing; block_end marks the last run of a chunk
// or of a terminated stream.
// The APB port holds format_mode at byte address 0: 0 ends a stream at
// 00 ED ED 00, 1 reads chunks that start with a length and page header.
// Writing it restarts parsing; write only while the decoder is idle.
// Throughput: one input byte per cycle while the run queue is not full. A
// byte releases zero to three runs, and run_out carries one run per cycle
// while ready is high, so the sustained input rate is set by the number of
// runs per byte on the output register. Path: the parser decodes a byte
// combinationally and writes its runs into the run queue as the byte is
// accepted; each run then goes from the queue head into the output register.
// When run_out stalls, the run queue fills and byte_in drops ready once it is
// full; parsing resumes as soon as an entry leaves the queue.
// Reset clears the parser to the start of a terminated stream, format_mode to
// 0 and the run queue to empty.
module ed_rle_page_decoder #(
  parameter int QUEUE_DEPTH = erpd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  erpd_in_if.sink                         byte_in,
  erpd_out_if.source                      run_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [erpd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [erpd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [erpd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  erpd_pkg::run_entry_t push_entry, head;
  logic push, pop, empty, full;
  logic cfg_wr, format_mode;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == erpd_pkg::REG_FORMAT_MODE);
  assign prdata = (paddr[2] == erpd_pkg::REG_FORMAT_MODE) ?
                  {{(erpd_pkg::APB_DATA_W-1){1'b0}}, format_mode} : '0;

  erpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .cfg_mode    (pwdata[0]),
    .format_mode (format_mode),
    .byte_in     (byte_in),
    .queue_full  (full),
    .push        (push),
    .entry       (push_entry)
  );

  erpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  erpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .run_out (run_out)
  );

endmodule

// ===== rtl/erpd_front.sv =====
module erpd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic                  cfg_mode,
  output logic                  format_mode,
  erpd_in_if.sink               byte_in,
  input  logic                  queue_full,
  output logic                  push,
  output erpd_pkg::run_entry_t  entry
);

  erpd_pkg::phase_t phase, phase_next;
  logic [7:0]  held_count, held_count_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]  current_page, current_page_next;
  logic [15:0] rem_dec;
  logic [7:0]  b;
  logic        accept;
  logic        chunk_tok;

  assign b            = byte_in.data_byte;
  assign byte_in.ready = !queue_full;
  assign accept       = byte_in.valid && byte_in.ready;
  assign push         = accept && (entry.n != 2'd0);
  assign rem_dec      = (bytes_remaining != 16'd0) ? bytes_remaining - 16'd1 : 16'd0;

  always_comb begin
    phase_next           = phase;
    held_count_next      = held_count;
    bytes_remaining_next = bytes_remaining;
    current_page_next    = current_page;
    chunk_tok            = 1'b0;
    entry                = '0;
    entry.page           = current_page;
    unique case (phase)
      erpd_pkg::PH_T_IDLE: begin
        if (b == erpd_pkg::ZERO_BYTE) begin
          phase_next = erpd_pkg::PH_T_Z;
        end else if (b == erpd_pkg::MARK_BYTE) begin
          phase_next = erpd_pkg::PH_T_E;
        end else begin
          entry.n      = 2'd1;
          entry.val[0] = b;
          entry.len[0] = 8'd1;
        end
      end
      erpd_pkg::PH_T_E: begin
        if (b == erpd_pkg::MARK_BYTE) begin
          phase_next = erpd_pkg::PH_T_EE;
        end else begin
          entry.n      = 2'd2;
          entry.val[0] = erpd_pkg::MARK_BYTE;
          entry.len[0] = 8'd1;
          entry.val[1] = b;
          entry.len[1] = 8'd1;
          phase_next   = erpd_pkg::PH_T_IDLE;
        end
      end
      erpd_pkg::PH_T_EE: begin
        held_count_next = b;
        phase_next      = erpd_pkg::PH_T_EEN;
      end
      erpd_pkg::PH_T_EEN: begin
        entry.n      = 2'd1;
        entry.val[0] = b;
        entry.len[0] = held_count;
        phase_next   = erpd_pkg::PH_T_IDLE;
      end
      erpd_pkg::PH_T_Z: begin
        if (b == erpd_pkg::MARK_BYTE) begin
          phase_next = erpd_pkg::PH_T_ZE;
        end else if (b == erpd_pkg::ZERO_BYTE) begin
          entry.n      = 2'd1;
          entry.val[0] = erpd_pkg::ZERO_BYTE;
          entry.len[0] = 8'd1;
        end else begin
          entry.n      = 2'd2;
          entry.val[0] = erpd_pkg::ZERO_BYTE;
          entry.len[0] = 8'd1;
          entry.val[1] = b;
          entry.len[1] = 8'd1;
          phase_next   = erpd_pkg::PH_T_IDLE;
        end
      end
      erpd_pkg::PH_T_ZE: begin
        if (b == erpd_pkg::MARK_BYTE) begin
          phase_next = erpd_pkg::PH_T_ZEE;
        end else begin
          entry.n      = 2'd3;
          entry.val[0] = erpd_pkg::ZERO_BYTE;
          entry.len[0] = 8'd1;
          entry.val[1] = erpd_pkg::MARK_BYTE;
          entry.len[1] = 8'd1;
          entry.val[2] = b;
          entry.len[2] = 8'd1;
          phase_next   = erpd_pkg::PH_T_IDLE;
        end
      end
      erpd_pkg::PH_T_ZEE: begin
        entry.n = 2'd1;
        if (b == erpd_pkg::ZERO_BYTE) begin
          entry.val[0]   = erpd_pkg::ZERO_BYTE;
          entry.len[0]   = 8'd0;
          entry.last_end = 1'b1;
          phase_next     = erpd_pkg::PH_T_IDLE;
        end else begin
          entry.val[0]    = erpd_pkg::ZERO_BYTE;
          entry.len[0]    = 8'd1;
          held_count_next = b;
          phase_next      = erpd_pkg::PH_T_EEN;
        end
      end
      erpd_pkg::PH_C_H0: begin
        bytes_remaining_next = {8'd0, b};
        phase_next           = erpd_pkg::PH_C_H1;
      end
      erpd_pkg::PH_C_H1: begin
        bytes_remaining_next = {b, bytes_remaining[7:0]};
        phase_next           = erpd_pkg::PH_C_H2;
      end
      erpd_pkg::PH_C_H2: begin
        current_page_next = b;
        if (bytes_remaining == 16'd0) begin
          entry.n        = 2'd1;
          entry.page     = b;
          entry.last_end = 1'b1;
          phase_next     = erpd_pkg::PH_C_H0;
        end else begin
          phase_next = erpd_pkg::PH_C_D;
        end
      end
      erpd_pkg::PH_C_D: begin
        bytes_remaining_next = rem_dec;
        if (b == erpd_pkg::MARK_BYTE) begin
          phase_next = erpd_pkg::PH_C_E;
        end else begin
          entry.n      = 2'd1;
          entry.val[0] = b;
          entry.len[0] = 8'd1;
          chunk_tok    = 1'b1;
        end
      end
      erpd_pkg::PH_C_E: begin
        bytes_remaining_next = rem_dec;
        if (b == erpd_pkg::MARK_BYTE) begin
          phase_next = erpd_pkg::PH_C_EE;
        end else begin
          entry.n      = 2'd2;
          entry.val[0] = erpd_pkg::MARK_BYTE;
          entry.len[0] = 8'd1;
          entry.val[1] = b;
          entry.len[1] = 8'd1;
          chunk_tok    = 1'b1;
        end
      end
      erpd_pkg::PH_C_EE: begin
        bytes_remaining_next = rem_dec;
        held_count_next      = b;
        phase_next           = erpd_pkg::PH_C_EEN;
      end
      erpd_pkg::PH_C_EEN: begin
        bytes_remaining_next = rem_dec;
        entry.n      = 2'd1;
        entry.val[0] = b;
        entry.len[0] = held_count;
        chunk_tok    = 1'b1;
      end
      default: begin
        phase_next = format_mode ? erpd_pkg::PH_C_H0 : erpd_pkg::PH_T_IDLE;
      end
    endcase
    if (chunk_tok) begin
      if (rem_dec == 16'd0) begin
        entry.last_end = 1'b1;
        phase_next     = erpd_pkg::PH_C_H0;
      end else begin
        phase_next = erpd_pkg::PH_C_D;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode     <= erpd_pkg::MODE_TERMINATED;
      phase           <= erpd_pkg::PH_T_IDLE;
      held_count      <= 8'd0;
      bytes_remaining <= 16'd0;
      current_page    <= 8'd0;
    end else if (cfg_wr) begin
      format_mode     <= cfg_mode;
      phase           <= cfg_mode ? erpd_pkg::PH_C_H0 : erpd_pkg::PH_T_IDLE;
      held_count      <= 8'd0;
      bytes_remaining <= 16'd0;
      current_page    <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      held_count      <= held_count_next;
      bytes_remaining <= bytes_remaining_next;
      current_page    <= current_page_next;
    end
  end

endmodule

// ===== rtl/erpd_queue.sv =====
module erpd_queue #(
  parameter int DEPTH = erpd_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  erpd_pkg::run_entry_t  push_entry,
  input  logic                  pop,
  output erpd_pkg::run_entry_t  head,
  output logic                  empty,
  output logic                  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  erpd_pkg::run_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full run queue");

  a_no_empty_entries: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_entry.n != 2'd0)) else $error("run entry with no results queued");

endmodule

// ===== rtl/erpd_back.sv =====
module erpd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  erpd_pkg::run_entry_t  head,
  input  logic                  empty,
  output logic                  pop,
  erpd_out_if.source            run_out
);

  logic       out_valid;
  logic [7:0] out_page, out_value, out_length;
  logic       out_end;
  logic [1:0] idx;
  logic       load, take, last_of_entry;

  assign load          = !out_valid || run_out.ready;
  assign take          = load && !empty;
  assign last_of_entry = ((idx + 2'd1) == head.n);
  assign pop           = take && last_of_entry;

  assign run_out.valid       = out_valid;
  assign run_out.page_number = out_page;
  assign run_out.run_value   = out_value;
  assign run_out.run_length  = out_length;
  assign run_out.block_end   = out_end;

  always_ff @(posedge clk) begin
    if (take) begin
      out_page   <= head.page;
      out_value  <= head.val[idx];
      out_length <= head.len[idx];
      out_end    <= head.last_end && last_of_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= !empty;
      if (take) begin
        idx <= last_of_entry ? 2'd0 : idx + 2'd1;
      end
    end
  end

  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (idx < head.n)) else $error("result index past entry size");

  a_idx_zero_when_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> (idx == 2'd0)) else $error("result index left over with empty queue");

endmodule
